/* hdl/nfbc_pkg.sv */
// Shared types, constants and the round function of the nibble Feistel byte cipher.
// No dependencies; used by every module in hdl/.
package nfbc_pkg;

    localparam int DATA_W    = 8;
    localparam int NIB_W     = 4;
    localparam int KEY_W     = 64;
    localparam int ROUNDS_W  = 5;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;

    localparam logic [KEY_W-1:0]    KEY_RESET    = '0;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd7;
    localparam logic                MODE_RESET   = 1'b0;

    // register index = paddr / 8
    typedef enum logic [1:0] {
        REG_KEY    = 2'd0,
        REG_ROUNDS = 2'd1,
        REG_MODE   = 2'd2
    } t_reg_idx;

    // per-cell control: round enable, direction and the cell's key byte
    typedef struct packed {
        logic              active;
        logic              decrypt;
        logic [DATA_W-1:0] key;
    } t_round_ctl;

    function automatic logic [NIB_W-1:0] round_f(
        input logic [NIB_W-1:0]  r,
        input logic [DATA_W-1:0] k
    );
        round_f = r ^ (k[NIB_W-1:0] & r) ^ k[DATA_W-1:NIB_W];
    endfunction

endpackage

/* hdl/nfbc_round_cell.sv */
// One round cell of the cipher chain: a pipeline register holding one byte in flight.
// Depends on nfbc_pkg (t_round_ctl, round_f).
module nfbc_round_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  nfbc_pkg::t_round_ctl    i_ctl,
    input  logic                    i_valid,
    input  logic [3:0]              i_left,
    input  logic [3:0]              i_right,
    output logic                    o_valid,
    output logic [3:0]              o_left,
    output logic [3:0]              o_right
);

    logic       r_valid;
    logic [3:0] r_left;
    logic [3:0] r_right;
    logic [3:0] n_left;
    logic [3:0] n_right;

    always_comb begin
        n_left  = i_left;
        n_right = i_right;
        if (i_ctl.active) begin
            if (i_ctl.decrypt) begin
                n_left  = i_right;
                n_right = i_left ^ nfbc_pkg::round_f(i_right, i_ctl.key);
            end else begin
                n_left  = i_right ^ nfbc_pkg::round_f(i_left, i_ctl.key);
                n_right = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

/* hdl/nfbc_cfg_regs.sv */
// APB-style configuration registers: key, round count and direction.
// Depends on nfbc_pkg (register indexes, reset values).
module nfbc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nfbc_pkg::APB_AW-1:0]     paddr,
    input  logic [nfbc_pkg::APB_DW-1:0]     pwdata,
    output logic [nfbc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    output logic [nfbc_pkg::KEY_W-1:0]      o_cipher_key,
    output logic [nfbc_pkg::ROUNDS_W-1:0]   o_round_count,
    output logic                            o_decrypt_mode
);

    logic [nfbc_pkg::KEY_W-1:0]    r_cipher_key;
    logic [nfbc_pkg::ROUNDS_W-1:0] r_round_count;
    logic                          r_decrypt_mode;
    logic                          wr_en;
    nfbc_pkg::t_reg_idx            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = nfbc_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key   <= nfbc_pkg::KEY_RESET;
            r_round_count  <= nfbc_pkg::ROUNDS_RESET;
            r_decrypt_mode <= nfbc_pkg::MODE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                nfbc_pkg::REG_KEY:    r_cipher_key   <= pwdata;
                nfbc_pkg::REG_ROUNDS: r_round_count  <= pwdata[nfbc_pkg::ROUNDS_W-1:0];
                nfbc_pkg::REG_MODE:   r_decrypt_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nfbc_pkg::REG_KEY:    prdata = r_cipher_key;
            nfbc_pkg::REG_ROUNDS: prdata = {{(nfbc_pkg::APB_DW-nfbc_pkg::ROUNDS_W){1'b0}},
                                            r_round_count};
            nfbc_pkg::REG_MODE:   prdata = {{(nfbc_pkg::APB_DW-1){1'b0}}, r_decrypt_mode};
            default:              prdata = '0;
        endcase
    end

    assign o_cipher_key   = r_cipher_key;
    assign o_round_count  = r_round_count;
    assign o_decrypt_mode = r_decrypt_mode;

endmodule

/* hdl/nibble_feistel_byte_cipher_unit.sv */
// Top level of the nibble Feistel byte cipher: config registers and the round-cell chain.
// Depends on nfbc_pkg, nfbc_cfg_regs and nfbc_round_cell.
//
// One byte in and one byte out per transaction, at a sustained rate of one byte per cycle
// while the output accepts results. Every byte passes through a chain of MAX_ROUNDS round
// cells, one register each, from input acceptance to the output; the last cell is the
// output register. The whole chain stalls together while a result waits. Encryption
// runs its rounds in the first round_count cells, decryption in the last round_count cells,
// which fixes each cell's key byte at build time. round_count above MAX_ROUNDS is treated
// as MAX_ROUNDS; key bytes at index KEY_BYTES and above are unused. Registers sit at byte
// addresses 0 (key), 8 (round count) and 16 (decrypt mode) and may be written only while
// no byte is in flight.
module nibble_feistel_byte_cipher_unit #(
    parameter int MAX_ROUNDS = 16,
    parameter int KEY_BYTES  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nfbc_pkg::APB_AW-1:0]     paddr,
    input  logic [nfbc_pkg::APB_DW-1:0]     pwdata,
    output logic [nfbc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_data_out
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
    localparam int CMP_W = (CNT_W > nfbc_pkg::ROUNDS_W) ? CNT_W : nfbc_pkg::ROUNDS_W;
    localparam logic [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROUNDS);

    logic [nfbc_pkg::KEY_W-1:0]    cipher_key;
    logic [nfbc_pkg::ROUNDS_W-1:0] round_count;
    logic                          decrypt_mode;
    logic [CMP_W-1:0]              rounds_ext;
    logic [CMP_W-1:0]              rounds_eff;
    logic                          advance;

    logic [MAX_ROUNDS:0] chain_valid;
    logic [3:0]          chain_left  [MAX_ROUNDS+1];
    logic [3:0]          chain_right [MAX_ROUNDS+1];

    nfbc_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_cipher_key   (cipher_key),
        .o_round_count  (round_count),
        .o_decrypt_mode (decrypt_mode)
    );

    assign rounds_ext = CMP_W'(round_count);
    assign rounds_eff = (rounds_ext > MAX_R) ? MAX_R : rounds_ext;

    assign advance    = !chain_valid[MAX_ROUNDS] || i_out_ready;
    assign o_in_ready = advance;

    assign chain_valid[0] = i_in_valid;
    assign chain_left[0]  = i_data_in[7:4];
    assign chain_right[0] = i_data_in[3:0];

    for (genvar p = 0; p < MAX_ROUNDS; p++) begin : g_cell
        localparam int ENC_IDX = p % KEY_BYTES;
        localparam int DEC_IDX = (MAX_ROUNDS - 1 - p) % KEY_BYTES;
        localparam logic [CMP_W-1:0] POS = CMP_W'(p);

        nfbc_pkg::t_round_ctl ctl;
        logic [CMP_W:0]       pos_sum;

        // decrypt round j sits in cell MAX_ROUNDS - n + j
        assign pos_sum     = {1'b0, POS} + {1'b0, rounds_eff};
        assign ctl.decrypt = decrypt_mode;
        assign ctl.active  = decrypt_mode ? (pos_sum >= {1'b0, MAX_R}) : (POS < rounds_eff);
        assign ctl.key     = decrypt_mode ? cipher_key[8*DEC_IDX +: 8]
                                          : cipher_key[8*ENC_IDX +: 8];

        nfbc_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_ctl   (ctl),
            .i_valid (chain_valid[p]),
            .i_left  (chain_left[p]),
            .i_right (chain_right[p]),
            .o_valid (chain_valid[p+1]),
            .o_left  (chain_left[p+1]),
            .o_right (chain_right[p+1])
        );
    end

    assign o_out_valid = chain_valid[MAX_ROUNDS];
    assign o_data_out  = {chain_left[MAX_ROUNDS], chain_right[MAX_ROUNDS]};

endmodule

/* bench/nfbc_checker.sv */
// Checker for the nibble Feistel byte cipher: tracks register writes on the APB port, predicts
// each output byte from the accepted input byte and compares it with the block's output.
// Depends on nfbc_pkg.
`timescale 1ns / 1ps

module nfbc_checker #(
    parameter int MAX_ROUNDS = 16,
    parameter int KEY_BYTES  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [nfbc_pkg::APB_AW-1:0]     i_paddr,
    input  logic [nfbc_pkg::APB_DW-1:0]     i_pwdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_data_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [7:0]                      i_data_out,
    output int                              o_fail_count,
    output int                              o_pending
);

    logic [nfbc_pkg::KEY_W-1:0]    key_reg;
    logic [nfbc_pkg::ROUNDS_W-1:0] rounds_reg;
    logic                          decrypt_reg;
    logic [7:0]                    cipher_q[$];

    function automatic logic [3:0] mix_nibble(input logic [3:0] r, input logic [7:0] k);
        return r ^ (k[3:0] & r) ^ k[7:4];
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] din);
        logic [3:0] lft;
        logic [3:0] rgt;
        logic [3:0] tmp;
        logic [7:0] kb;
        int         nrounds;
        nrounds = (rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_reg);
        lft = din[7:4];
        rgt = din[3:0];
        for (int j = 0; j < nrounds; j++) begin
            if (!decrypt_reg) begin
                kb  = key_reg[8*(j % KEY_BYTES) +: 8];
                tmp = rgt ^ mix_nibble(lft, kb);
                rgt = lft;
                lft = tmp;
            end else begin
                // reverse key order undoes the forward rounds
                kb  = key_reg[8*((nrounds - 1 - j) % KEY_BYTES) +: 8];
                tmp = lft ^ mix_nibble(rgt, kb);
                lft = rgt;
                rgt = tmp;
            end
        end
        return {lft, rgt};
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            key_reg      = nfbc_pkg::KEY_RESET;
            rounds_reg   = nfbc_pkg::ROUNDS_RESET;
            decrypt_reg  = nfbc_pkg::MODE_RESET;
            cipher_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[nfbc_pkg::APB_AW-1:3])
                    nfbc_pkg::REG_KEY:    key_reg     = i_pwdata[nfbc_pkg::KEY_W-1:0];
                    nfbc_pkg::REG_ROUNDS: rounds_reg  = i_pwdata[nfbc_pkg::ROUNDS_W-1:0];
                    nfbc_pkg::REG_MODE:   decrypt_reg = i_pwdata[0];
                    default:    ; // unmapped index, write dropped
                endcase
            end
            if (i_in_valid && i_in_ready)
                cipher_q.push_back(cipher_byte(i_data_in));
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    $error("data_out: unexpected transaction, got %02h", i_data_out);
                    o_fail_count++;
                end else begin
                    want = cipher_q.pop_front();
                    if (i_data_out !== want) begin
                        $error("data_out mismatch: expected %02h, actual %02h", want, i_data_out);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = cipher_q.size();
    end

endmodule

/* bench/tb.sv */
// Testbench top for nibble_feistel_byte_cipher_unit: reset, register writes over APB,
// directed and random byte traffic with random stalls on both sides, final verdict.
// Depends on nfbc_pkg, nfbc_checker and the block itself.
`timescale 1ns / 1ps

module tb;

    localparam int         MAX_ROUNDS   = 16;
    localparam int         KEY_BYTES    = 8;
    localparam int         RAND_PHASES  = 10;
    localparam int         PHASE_BYTES  = 75;
    localparam int         IDLE_PCT     = 35;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [nfbc_pkg::APB_AW-1:0]  paddr;
    logic [nfbc_pkg::APB_DW-1:0]  pwdata;
    logic [nfbc_pkg::APB_DW-1:0]  prdata;
    logic                         pready;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [7:0]                   i_data_in;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [7:0]                   o_data_out;
    int                           fail_count;
    int                           pending;
    bit                           calm;

    nibble_feistel_byte_cipher_unit #(
        .MAX_ROUNDS(MAX_ROUNDS),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_data_in  (i_data_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_data_out (o_data_out)
    );

    nfbc_checker #(
        .MAX_ROUNDS(MAX_ROUNDS),
        .KEY_BYTES (KEY_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_data_in   (i_data_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_data_out  (o_data_out),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // output-side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [nfbc_pkg::APB_DW-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_in  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop input traffic and let every byte in flight come out
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_cipher(input logic [63:0] key, input logic [4:0] rounds,
                              input logic decrypt);
        reg_write(nfbc_pkg::REG_KEY, key);
        reg_write(nfbc_pkg::REG_ROUNDS, {59'd0, rounds});
        reg_write(nfbc_pkg::REG_MODE, {63'd0, decrypt});
    endtask

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [63:0] key;
        logic [4:0]  rounds;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_in_valid = 1'b0;
        i_data_in  = '0;
        calm       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: zero key, 7 rounds, encrypt
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0F);
        send_byte(8'hF0);
        drain();

        // zero rounds passes the byte through
        set_cipher({$urandom, $urandom}, 5'd0, 1'b0);
        send_byte(8'hA5);
        send_byte(8'h5A);
        drain();

        // full rounds, every key byte used twice
        set_cipher(64'h0123_4567_89AB_CDEF, 5'd16, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        drain();

        // round count past the cap behaves as the cap, decrypt order
        set_cipher(64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hC3);
        drain();

        // write to an unmapped index must leave the settings alone
        reg_write(REG_UNMAPPED, {$urandom, $urandom});
        send_byte(8'h81);
        send_byte(8'h7E);
        drain();

        set_cipher({$urandom, $urandom}, 5'd1, 1'b1);
        send_byte(8'h12);
        send_byte(8'hED);
        drain();

        set_cipher({$urandom, $urandom}, 5'd17, 1'b0);
        send_byte(8'h96);
        send_byte(8'h69);
        drain();

        set_cipher(64'h0, 5'd9, 1'b1);
        send_byte(8'hFF);
        send_byte(8'h01);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(3))
                0:       key = '0;
                1:       key = '1;
                default: key = {$urandom, $urandom};
            endcase
            case ($urandom_range(5))
                0:       rounds = 5'd0;
                1:       rounds = 5'd16;
                2:       rounds = 5'd31;
                default: rounds = 5'($urandom_range(31));
            endcase
            set_cipher(key, rounds, 1'($urandom_range(1)));
            calm = (ph == RAND_PHASES / 2);
            for (int n = 0; n < PHASE_BYTES; n++)
                send_byte(8'($urandom_range(255)));
            drain();
            calm = 1'b0;
        end

        repeat (MAX_ROUNDS + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
